>>> hdl/ssrc_pkg.sv
// shared types and constants for the sorted set range count block
// no dependencies; used by every module in hdl
`timescale 1ns / 1ps

package ssrc_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 9;
  localparam int POS_W   = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] query_low;
    logic signed [POS_W-1:0] query_high;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               status;
  } out_word_t;

  // handed from each cell to the one above it
  typedef struct packed {
    logic signed [POS_W-1:0] value;
    logic                    gt;
  } cell_link_t;

  typedef struct packed {
    logic le;
    logic lt;
  } cell_flags_t;

endpackage

>>> hdl/ssrc_cell.sv
// one storage cell of the sorted chain: holds a position, shifts on insert
// depends on ssrc_pkg
`timescale 1ns / 1ps

module ssrc_cell (
  input  logic                      clk_i,
  input  logic [ssrc_pkg::IDX_W-1:0] idx_i,
  input  logic [ssrc_pkg::IDX_W-1:0] fill_i,
  input  logic                      shift_en_i,
  input  ssrc_pkg::in_word_t        word_i,
  input  ssrc_pkg::cell_link_t      prev_i,
  output ssrc_pkg::cell_link_t      link_o,
  output ssrc_pkg::cell_flags_t     flags_o
);

  logic signed [ssrc_pkg::POS_W-1:0] value_q, value_d;
  logic occ;
  logic gt;

  // empty cells act as plus infinity so the new key lands at the fill edge
  assign occ = idx_i < fill_i;
  assign gt  = !occ || (value_q > word_i.position);

  always_comb begin
    value_d = value_q;
    if (gt) begin
      value_d = prev_i.gt ? prev_i.value : word_i.position;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      value_q <= value_d;
    end
  end

  assign link_o.value = value_q;
  assign link_o.gt    = gt;
  assign flags_o.le   = occ && (value_q <= word_i.query_high);
  assign flags_o.lt   = occ && (value_q < word_i.query_low);

endmodule

>>> hdl/ssrc_encode.sv
// thermometer code to count: number of leading ones in a monotone flag row
// depends on ssrc_pkg
`timescale 1ns / 1ps

module ssrc_encode (
  input  logic [ssrc_pkg::DEPTH-1:0] therm_i,
  output logic [ssrc_pkg::IDX_W-1:0] num_o
);

  localparam int IdxW = ssrc_pkg::IDX_W;

  logic [ssrc_pkg::DEPTH-1:0] above;
  logic [ssrc_pkg::DEPTH-1:0] edge_bits;

  assign above     = {1'b0, therm_i[ssrc_pkg::DEPTH-1:1]};
  assign edge_bits = therm_i & ~above;

  // the edge is one-hot, so an or of indexes is the encoder
  always_comb begin
    num_o = '0;
    for (int i = 0; i < ssrc_pkg::DEPTH; i++) begin
      if (edge_bits[i]) begin
        num_o = num_o | IdxW'(i + 1);
      end
    end
  end

endmodule

>>> hdl/sorted_set_range_count_top.sv
// two register stages, stage a and the output register; the result word passes through stage a and
// then the output register, and stage a holds its word while a stalled output register is still full
// throughput: one word per cycle while in_stall_o is low; an insert shifts the whole cell chain at once
// a query registers its compare flags, then encodes and subtracts in the next stage
// reset clears the fill count and the pipeline valids; cell contents stay undefined
// depends on ssrc_pkg, ssrc_cell, ssrc_encode
`timescale 1ns / 1ps

module sorted_set_range_count_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssrc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssrc_pkg::out_word_t out_word_o
);

  localparam int Depth  = ssrc_pkg::DEPTH;
  localparam int IdxW   = ssrc_pkg::IDX_W;
  localparam int CountW = ssrc_pkg::COUNT_W;

  // fill count: cells below it hold the sorted positions
  logic [IdxW-1:0] fill_q, fill_d;

  // stage a: compare flags or finished count
  logic              a_valid_q;
  logic              a_query_q;
  logic [Depth-1:0]  a_le_q, a_lt_q;
  logic [CountW-1:0] a_count_q, a_count_d;
  logic              a_status_q, a_status_d;

  // output register
  logic                out_valid_q;
  ssrc_pkg::out_word_t out_word_q;

  logic accept, a_move, out_free, full, shift_en;
  logic query_ok;

  ssrc_pkg::cell_link_t  links [Depth];
  ssrc_pkg::cell_flags_t flags [Depth];
  ssrc_pkg::cell_link_t  chain_base;
  logic [Depth-1:0]      le_row, lt_row;
  logic [IdxW-1:0]       num_le, num_lt;
  logic [IdxW-1:0]       span;

  // handshake: stage a drains into the output register when it is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign a_move     = a_valid_q && out_free;
  assign in_stall_o = a_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = fill_q == IdxW'(Depth);
  assign shift_en = accept && (in_word_i.operation == ssrc_pkg::OP_INSERT) && !full;
  assign query_ok = in_word_i.query_low <= in_word_i.query_high;

  // bottom of the chain never shifts anything in
  assign chain_base.value = in_word_i.position;
  assign chain_base.gt    = 1'b0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    ssrc_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IdxW'(g)),
      .fill_i     (fill_q),
      .shift_en_i (shift_en),
      .word_i     (in_word_i),
      .prev_i     ((g == 0) ? chain_base : links[(g == 0) ? 0 : g - 1]),
      .link_o     (links[g]),
      .flags_o    (flags[g])
    );
    assign le_row[g] = flags[g].le;
    assign lt_row[g] = flags[g].lt;
  end

  // fill count and the count reported for non-query words
  always_comb begin
    fill_d     = fill_q;
    a_count_d  = CountW'(fill_q);
    a_status_d = 1'b0;
    unique case (in_word_i.operation)
      ssrc_pkg::OP_CLEAR: begin
        fill_d    = '0;
        a_count_d = '0;
      end
      ssrc_pkg::OP_INSERT: begin
        if (full) begin
          a_status_d = 1'b1;
        end else begin
          fill_d    = fill_q + IdxW'(1);
          a_count_d = CountW'(fill_q + IdxW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage a payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_query_q  <= (in_word_i.operation == ssrc_pkg::OP_QUERY);
      a_le_q     <= query_ok ? le_row : '0;
      a_lt_q     <= query_ok ? lt_row : '0;
      a_count_q  <= a_count_d;
      a_status_q <= a_status_d;
    end
  end

  // sorted store: in-range count is the gap between the two flag edges
  ssrc_encode u_enc_le (
    .therm_i (a_le_q),
    .num_o   (num_le)
  );

  ssrc_encode u_enc_lt (
    .therm_i (a_lt_q),
    .num_o   (num_lt)
  );

  assign span = num_le - num_lt;

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      out_word_q.count  <= a_query_q ? CountW'(span) : a_count_q;
      out_word_q.status <= a_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
